FILE: rtl/ggc_pkg.sv
// Shared types, codes and pin group table of the grouped GPIO controller.
package ggc_pkg;

   localparam int GROUP_COUNT = 18;
   localparam int PIN_W = 7;
   localparam int GROUP_W = 5;
   localparam int BIT_W = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic [2:0] OP_SET_INPUT = 3'd0;
   localparam logic [2:0] OP_SET_OUTPUT = 3'd1;
   localparam logic [2:0] OP_SET_LEVEL = 3'd2;
   localparam logic [2:0] OP_READ_LEVEL = 3'd3;
   localparam logic [2:0] OP_READ_DIR = 3'd4;
   localparam logic [2:0] OP_CLAIM = 3'd5;
   localparam logic [2:0] OP_RELEASE = 3'd6;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_BUSY = 2'd2;
   localparam logic [1:0] ST_NOT_CLAIMED = 2'd3;

   localparam logic [GROUP_W-1:0] GRP_LATCH_A = 5'd10;
   localparam logic [GROUP_W-1:0] GRP_LATCH_B = 5'd13;
   localparam logic [GROUP_W-1:0] GRP_LATCH_C = 5'd14;

   localparam logic [PIN_W-1:0] GRP_LO [GROUP_COUNT] = '{
      7'd0, 7'd16, 7'd20, 7'd22, 7'd26, 7'd30, 7'd32, 7'd40, 7'd48,
      7'd61, 7'd65, 7'd69, 7'd74, 7'd78, 7'd80, 7'd82, 7'd85, 7'd87
   };
   localparam logic [PIN_W-1:0] GRP_HI [GROUP_COUNT] = '{
      7'd15, 7'd19, 7'd21, 7'd25, 7'd29, 7'd31, 7'd39, 7'd47, 7'd60,
      7'd64, 7'd68, 7'd73, 7'd77, 7'd79, 7'd81, 7'd84, 7'd86, 7'd88
   };

   typedef struct packed {
      logic [2:0] req_type;
      logic [PIN_W-1:0] pin;
      logic level;
      logic pad_level;
   } req_type_type;

   typedef struct packed {
      logic hit;
      logic [GROUP_W-1:0] group_index;
      logic [BIT_W-1:0] bit_in_group;
   } pin_decode_type;

   typedef struct packed {
      logic read_level;
      logic is_output;
      logic [GROUP_W-1:0] group_index;
      logic [BIT_W-1:0] bit_in_group;
      logic [1:0] status;
   } rsp_item_type;

endpackage

FILE: rtl/grouped_gpio_controller_top.sv
// A request is registered in the execute stage and its response in the output register.
// Throughput: one request per cycle unless rsp_tready stalls the output register; the
// per-pin state is read, updated and written in the single execute stage, so back-to-back
// requests on one pin see each other's effects. Reset (synchronous, active high) clears
// all directions to input, all latches and all claims, and empties both pipeline
// registers.
module grouped_gpio_controller_top #(
   parameter int NUM_PINS = 89
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // req_type[2:0], pin[9:3], level[10], pad_level[11], zero[15:12]
   input  logic [ggc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // read_level[0], is_output[1], group_index[6:2], bit_in_group[10:7],
   // status[12:11], zero[15:13]
   output logic [ggc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import ggc_pkg::*;

   localparam int IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

   logic s1_valid_ff, s1_valid_in;
   req_type_type s1_req_ff;
   logic out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic [NUM_PINS-1:0] dir_ff, dir_in;
   logic [NUM_PINS-1:0] latch_ff, latch_in;
   logic [NUM_PINS-1:0] claim_ff, claim_in;

   logic out_free;
   logic advance;
   logic pin_ok;
   logic [IDX_W-1:0] idx;
   logic cur_dir, cur_latch, cur_claim;
   logic latch_group;
   pin_decode_type decode;

   ggc_pin_decode u_decode (
      .pin    (s1_req_ff.pin),
      .decode (decode)
   );

   assign out_free = !out_valid_ff || rsp_tready;
   assign advance = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   assign pin_ok = decode.hit && ({1'b0, s1_req_ff.pin} < 8'(NUM_PINS));
   assign idx = IDX_W'(s1_req_ff.pin);
   assign cur_dir = dir_ff[idx];
   assign cur_latch = latch_ff[idx];
   assign cur_claim = claim_ff[idx];
   assign latch_group = (decode.group_index == GRP_LATCH_A) ||
                        (decode.group_index == GRP_LATCH_B) ||
                        (decode.group_index == GRP_LATCH_C);

   always_comb begin
      dir_in = dir_ff;
      latch_in = latch_ff;
      claim_in = claim_ff;
      out_item_in.read_level = 1'b0;
      out_item_in.is_output = cur_dir;
      out_item_in.group_index = decode.group_index;
      out_item_in.bit_in_group = decode.bit_in_group;
      out_item_in.status = ST_OK;
      if (!pin_ok) begin
         out_item_in = '0;
         out_item_in.status = ST_INVALID;
      end else begin
         case (s1_req_ff.req_type)
            OP_SET_INPUT: begin
               dir_in[idx] = 1'b0;
               out_item_in.is_output = 1'b0;
            end
            OP_SET_OUTPUT: begin
               dir_in[idx] = 1'b1;
               latch_in[idx] = s1_req_ff.level;
               out_item_in.is_output = 1'b1;
            end
            OP_SET_LEVEL: begin
               latch_in[idx] = s1_req_ff.level;
            end
            OP_READ_LEVEL: begin
               out_item_in.read_level = (latch_group && cur_dir) ? cur_latch
                                                                 : s1_req_ff.pad_level;
            end
            OP_CLAIM: begin
               if (cur_claim) begin
                  out_item_in.status = ST_BUSY;
               end else begin
                  claim_in[idx] = 1'b1;
               end
            end
            OP_RELEASE: begin
               if (cur_claim) begin
                  claim_in[idx] = 1'b0;
               end else begin
                  out_item_in.status = ST_NOT_CLAIMED;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         dir_ff <= '0;
         latch_ff <= '0;
         claim_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            dir_ff <= dir_in;
            latch_ff <= latch_in;
            claim_ff <= claim_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_req_ff.req_type <= req_tdata[2:0];
         s1_req_ff.pin <= req_tdata[9:3];
         s1_req_ff.level <= req_tdata[10];
         s1_req_ff.pad_level <= req_tdata[11];
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {3'b000, out_item_ff.status, out_item_ff.bit_in_group,
                       out_item_ff.group_index, out_item_ff.is_output,
                       out_item_ff.read_level};

`ifndef NO_ASSERTIONS
   a_invalid_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[12:11] == ST_INVALID) |-> (rsp_tdata[10:0] == '0))
      else $error("invalid pin response carries nonzero fields");

   a_group_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:2] < 5'(GROUP_COUNT)))
      else $error("group index out of range");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output register");
`endif

endmodule

FILE: rtl/ggc_pin_decode.sv
// Pin to group and bit position decoder built from parallel range compares.
module ggc_pin_decode (
   input  logic [ggc_pkg::PIN_W-1:0] pin,
   output ggc_pkg::pin_decode_type   decode
);
   import ggc_pkg::*;

   logic [GROUP_COUNT-1:0] in_range;
   logic [PIN_W-1:0] base;

   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         in_range[g] = (pin >= GRP_LO[g]) && (pin <= GRP_HI[g]);
      end
   end

   always_comb begin
      decode.hit = 1'b0;
      decode.group_index = '0;
      base = '0;
      for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
         if (in_range[g]) begin
            decode.hit = 1'b1;
            decode.group_index = GROUP_W'(g);
            base = GRP_LO[g];
         end
      end
      decode.bit_in_group = BIT_W'(pin - base);
   end

endmodule
